// ===== hdl/rpn_pkg.sv =====
// Package for the postfix stack calculator: symbol codes, status codes,
// controller state type and stack sizing. No dependencies.
package rpn_pkg;
    localparam int StackDepth = 16;
    localparam int PtrW       = $clog2(StackDepth);
    localparam int CntW       = $clog2(StackDepth + 1);
    localparam int DataW      = 32;
    localparam int StepW      = $clog2(DataW + 1);

    localparam logic [7:0] SYM_ZERO = 8'd48;
    localparam logic [7:0] SYM_NINE = 8'd57;
    localparam logic [7:0] SYM_ADD  = 8'h2B;
    localparam logic [7:0] SYM_SUB  = 8'h2D;
    localparam logic [7:0] SYM_MUL  = 8'h2A;
    localparam logic [7:0] SYM_DIV  = 8'h2F;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_SYMBOL = 3'd1;
    localparam logic [2:0] ST_DIV_ZERO   = 3'd2;
    localparam logic [2:0] ST_UNDERFLOW  = 3'd3;
    localparam logic [2:0] ST_OVERFLOW   = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LOAD,
        S_ITER,
        S_WRITE,
        S_REPORT
    } t_state;
endpackage

// ===== hdl/postfix_stack_calculator.sv =====
// Top level of the postfix stack calculator: decoder, operand stack memory,
// bit-serial add/sub/mul/div datapath and result strobe. Uses rpn_pkg.
//
//   channel | ports                                      | handshake
//   --------+--------------------------------------------+----------------------
//   command | i_symbol[7:0]                              | start & !busy
//   result  | o_top_value, o_depth, o_status, o_finished | o_valid, one cycle
//
// Digits and refused symbols pass through a decode state (S_READ) and a report
// state (S_REPORT) before the strobe. Operators add a stack read and load
// (S_LOAD), 32 bit-serial steps of the shift/add datapath (S_ITER) and a
// write-back (S_WRITE) before the report. busy drops in the strobe cycle, so
// the next transaction can be accepted at its closing edge. Reset
// (i_rst_n low, synchronous) empties the stack; the memory is not cleared.
// The receiver cannot stall the results.
module postfix_stack_calculator
    import rpn_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [7:0]              i_symbol,
    output logic                    o_valid,
    output logic signed [DataW-1:0] o_top_value,
    output logic [4:0]              o_depth,
    output logic [2:0]              o_status,
    output logic                    o_finished
);
    // operand stack memory
    logic [DataW-1:0] r_mem [StackDepth];
    logic [DataW-1:0] r_rdata;
    logic [PtrW-1:0]  n_raddr;
    logic             n_we;
    logic [PtrW-1:0]  n_waddr;
    logic [DataW-1:0] n_wdata;

    t_state r_state, n_state;
    logic [CntW-1:0]  r_count, n_count;
    logic [7:0]       r_sym, n_sym;
    logic [DataW-1:0] r_top, n_top;      // cached top of stack
    logic [DataW-1:0] r_left, n_left;    // left operand / shifting dividend
    logic [DataW-1:0] r_right, n_right;  // right operand / shifting multiplicand
    logic [DataW-1:0] r_acc, n_acc;      // result / remainder
    logic [DataW-1:0] r_quo, n_quo;      // quotient or sum bits
    logic             r_carry, n_carry;
    logic             r_nl, n_nl, r_nr, n_nr;
    logic [StepW-1:0] r_step, n_step;
    logic [2:0]       r_status, n_status;
    logic             r_fin, n_fin;
    logic             r_valid, n_valid;

    logic [DataW-1:0] s_rem, s_diff, s_res;
    logic             s_sbit, s_cout, s_rb;
    logic             s_digit, s_op;

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_top_value = (r_count == '0) ? '0 : r_top;
    assign o_depth     = 5'(r_count);
    assign o_status    = r_status;
    assign o_finished  = r_fin;

    // write and read the stack memory
    always_ff @(posedge i_clk) begin
        if (n_we) begin
            r_mem[n_waddr] <= n_wdata;
        end
        r_rdata <= r_mem[n_raddr];
    end

    // hold control and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_valid  <= 1'b0;
            r_status <= ST_OK;
            r_fin    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_valid  <= n_valid;
            r_status <= n_status;
            r_fin    <= n_fin;
        end
        r_sym   <= n_sym;
        r_top   <= n_top;
        r_left  <= n_left;
        r_right <= n_right;
        r_acc   <= n_acc;
        r_quo   <= n_quo;
        r_carry <= n_carry;
        r_nl    <= n_nl;
        r_nr    <= n_nr;
        r_step  <= n_step;
    end

    assign s_digit = (r_sym >= SYM_ZERO) && (r_sym <= SYM_NINE);
    assign s_op    = (r_sym == SYM_ADD) || (r_sym == SYM_SUB) ||
                     (r_sym == SYM_MUL) || (r_sym == SYM_DIV);
    // restoring division step on magnitudes
    assign s_rem   = {r_acc[DataW-2:0], r_left[DataW-1]};
    assign s_diff  = s_rem - r_right;
    // one-bit adder for add/sub
    assign s_rb    = (r_sym == SYM_SUB) ? ~r_right[0] : r_right[0];
    assign {s_cout, s_sbit} = {1'b0, r_left[0]} + {1'b0, s_rb} + {1'b0, r_carry};
    always_comb begin
        case (r_sym)
            SYM_DIV: s_res = (r_nl ^ r_nr) ? (~r_quo + 1'b1) : r_quo;
            SYM_MUL: s_res = r_acc;
            default: s_res = r_quo;
        endcase
    end

    // advance the sequencer
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_sym    = r_sym;
        n_top    = r_top;
        n_left   = r_left;
        n_right  = r_right;
        n_acc    = r_acc;
        n_quo    = r_quo;
        n_carry  = r_carry;
        n_nl     = r_nl;
        n_nr     = r_nr;
        n_step   = r_step;
        n_status = r_status;
        n_fin    = r_fin;
        n_valid  = 1'b0;
        n_raddr  = PtrW'(r_count - 2'd2);
        n_we     = 1'b0;
        n_waddr  = PtrW'(r_count);
        n_wdata  = r_top;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_sym   = i_symbol;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_fin    = 1'b0;
                n_status = ST_OK;
                n_state  = S_REPORT;
                if (s_digit) begin
                    if (r_count >= CntW'(StackDepth)) begin
                        n_status = ST_OVERFLOW;
                    end else begin
                        n_we    = 1'b1;
                        n_wdata = DataW'(r_sym - SYM_ZERO);
                        n_top   = n_wdata;
                        n_count = r_count + 1'b1;
                    end
                end else if (s_op) begin
                    if (r_count < CntW'(2)) begin
                        n_status = ST_UNDERFLOW;
                    end else if (r_sym == SYM_DIV && r_top == '0) begin
                        n_status = ST_DIV_ZERO;
                    end else begin
                        n_state = S_LOAD;
                    end
                end else begin
                    n_status = ST_BAD_SYMBOL;
                end
            end
            S_LOAD: begin
                // left from memory, right from the cached top
                n_nl    = r_rdata[DataW-1];
                n_nr    = r_top[DataW-1];
                n_carry = (r_sym == SYM_SUB);
                n_acc   = '0;
                n_quo   = '0;
                n_step  = '0;
                if (r_sym == SYM_DIV) begin
                    n_left  = r_rdata[DataW-1] ? (~r_rdata + 1'b1) : r_rdata;
                    n_right = r_top[DataW-1] ? (~r_top + 1'b1) : r_top;
                end else begin
                    n_left  = r_rdata;
                    n_right = r_top;
                end
                n_state = S_ITER;
            end
            S_ITER: begin
                case (r_sym)
                    SYM_DIV: begin
                        n_left = {r_left[DataW-2:0], 1'b0};
                        if (s_rem >= r_right) begin
                            n_acc = s_diff;
                            n_quo = {r_quo[DataW-2:0], 1'b1};
                        end else begin
                            n_acc = s_rem;
                            n_quo = {r_quo[DataW-2:0], 1'b0};
                        end
                    end
                    SYM_MUL: begin
                        // shift-add: left bit picks right shifted into place
                        n_left  = {1'b0, r_left[DataW-1:1]};
                        n_right = {r_right[DataW-2:0], 1'b0};
                        n_acc   = r_left[0] ? (r_acc + r_right) : r_acc;
                    end
                    default: begin
                        n_left  = {1'b0, r_left[DataW-1:1]};
                        n_right = {1'b0, r_right[DataW-1:1]};
                        n_carry = s_cout;
                        n_quo   = {s_sbit, r_quo[DataW-1:1]};
                    end
                endcase
                n_step = r_step + 1'b1;
                if (r_step == StepW'(DataW - 1)) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                n_we    = 1'b1;
                n_waddr = PtrW'(r_count - 2'd2);
                n_wdata = s_res;
                n_top   = s_res;
                n_count = r_count - 1'b1;
                n_fin   = (r_count == CntW'(2));
                n_state = S_REPORT;
            end
            S_REPORT: begin
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
